// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker in rtl/slt_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the condition.
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// File: rtl/slt_pkg.sv
// Package for the script lexer: token kinds, lexer states, keyword table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;
   localparam int KEYWORD_COUNT_DEF = 44;
   localparam int MAX_KEYWORD_LENGTH_DEF = 10;
   localparam int KW_TABLE_SIZE = 44;
   localparam int KW_TEXT_MAX = 10;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [6:0] K_EOF = 7'd0;
   localparam logic [6:0] K_SYMBOL = 7'd1;
   localparam logic [6:0] K_INTEGER = 7'd2;
   localparam logic [6:0] K_FLOAT = 7'd3;
   localparam logic [6:0] K_STRING = 7'd4;
   localparam logic [6:0] K_LPAREN = 7'd5;
   localparam logic [6:0] K_RPAREN = 7'd6;
   localparam logic [6:0] K_LBRACK = 7'd7;
   localparam logic [6:0] K_RBRACK = 7'd8;
   localparam logic [6:0] K_PLUS = 7'd9;
   localparam logic [6:0] K_MINUS = 7'd10;
   localparam logic [6:0] K_STAR = 7'd11;
   localparam logic [6:0] K_PERCENT = 7'd12;
   localparam logic [6:0] K_COMMA = 7'd13;
   localparam logic [6:0] K_DOT = 7'd14;
   localparam logic [6:0] K_SEMI = 7'd15;
   localparam logic [6:0] K_SLASH = 7'd16;
   localparam logic [6:0] K_COLON = 7'd17;
   localparam logic [6:0] K_DCOLON = 7'd18;
   localparam logic [6:0] K_ASSIGN = 7'd19;
   localparam logic [6:0] K_EQ = 7'd20;
   localparam logic [6:0] K_LESS = 7'd21;
   localparam logic [6:0] K_LESSEQ = 7'd22;
   localparam logic [6:0] K_DIFF = 7'd23;
   localparam logic [6:0] K_GREATER = 7'd24;
   localparam logic [6:0] K_GREATEREQ = 7'd25;
   localparam logic [6:0] K_ERR_CHAR = 7'd69;
   localparam logic [6:0] K_ERR_OCTAL = 7'd70;
   localparam logic [6:0] K_ERR_COMMENT = 7'd71;
   localparam logic [6:0] K_ERR_STRING = 7'd72;
   localparam logic K_MAX_OK = 1'b1;

   typedef enum logic [14:0] {
      ST_START     = 15'd1 << 0,
      ST_STRING    = 15'd1 << 1,
      ST_STRESC    = 15'd1 << 2,
      ST_SYMBOL    = 15'd1 << 3,
      ST_BRACED    = 15'd1 << 4,
      ST_INTEGER   = 15'd1 << 5,
      ST_FLOAT     = 15'd1 << 6,
      ST_GREATER   = 15'd1 << 7,
      ST_LESS      = 15'd1 << 8,
      ST_EQ        = 15'd1 << 9,
      ST_COLON     = 15'd1 << 10,
      ST_SLASH     = 15'd1 << 11,
      ST_LINECOM   = 15'd1 << 12,
      ST_BLOCKCOM  = 15'd1 << 13,
      ST_BLOCKSTAR = 15'd1 << 14
   } lex_state_type;

   // One queued result pair; second slot valid only when two results.
   typedef struct packed {
      logic       r0_kind;
      logic [6:0] r0_tok;
      logic [7:0] r0_byte;
      logic       has_r1;
      logic [6:0] r1_tok;
   } qentry_type;

   function automatic logic [7:0] kw_char(input int k, input int pos);
      string s;
      case (k)
         0: s = "PROGRAM";    1: s = "IMPORT";   2: s = "BEGIN";    3: s = "END";
         4: s = "CALL";       5: s = "FOR";      6: s = "TO";       7: s = "STEP";
         8: s = "WHILE";      9: s = "DO";       10: s = "WITH";    11: s = "AS";
         12: s = "OF";        13: s = "ARRAY";   14: s = "RETURNS"; 15: s = "VAR";
         16: s = "IF";        17: s = "THEN";    18: s = "ELSE";    19: s = "AND";
         20: s = "OR";        21: s = "NOT";     22: s = "NEW";     23: s = "COPYOF";
         24: s = "DETACH";    25: s = "SIZEOF";  26: s = "DELETE";  27: s = "TYPE";
         28: s = "TYPENS";    29: s = "ISSET";   30: s = "ISNULL";  31: s = "ISTYPE";
         32: s = "ISINSTANCE"; 33: s = "STRLEN"; 34: s = "EXTERNAL"; 35: s = "RETURN";
         36: s = "TRY";       37: s = "CATCH";   38: s = "THROW";   39: s = "DEFINE";
         40: s = "EXTENSION"; 41: s = "TRUE";    42: s = "FALSE";   43: s = "NULL";
         default: s = "";
      endcase
      if (pos < s.len()) return s.getc(pos);
      return 8'd0;
   endfunction

   function automatic logic [3:0] kw_len(input int k);
      int n;
      n = 0;
      for (int p = 0; p < KW_TEXT_MAX; p++) begin
         if (kw_char(k, p) != 8'd0) n = p + 1;
      end
      return 4'(n);
   endfunction

   function automatic logic [6:0] kw_kind(input int k);
      if (k == 43) return 7'd68;
      if (k == 42) return 7'd67;
      return 7'(26 + k);
   endfunction
endpackage
`default_nettype wire

// File: rtl/slt_if.sv
// Valid/ready stream interfaces for lexer requests and responses.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface slt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_input;
   modport source (output valid, char_byte, end_of_input, input ready);
   modport sink (input valid, char_byte, end_of_input, output ready);
endinterface

interface slt_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [6:0] token_kind;
   logic [7:0] text_byte;
   logic       last;
   modport source (output valid, result_kind, token_kind, text_byte, last, input ready);
   modport sink (input valid, result_kind, token_kind, text_byte, last, output ready);
endinterface
`default_nettype wire

// File: rtl/slt_front.sv
// Lexer front end: state machine, escapes, keyword match; at most one entry per accepted byte.
// Depends on slt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slt_front #(
   parameter int KEYWORD_COUNT = slt_pkg::KEYWORD_COUNT_DEF,
   parameter int MAX_KEYWORD_LENGTH = slt_pkg::MAX_KEYWORD_LENGTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_char,
   input  wire logic                 in_eoi,
   output logic                      in_ready,
   output logic                      q_push,
   output slt_pkg::qentry_type       q_data,
   input  wire logic                 q_full
);
   import slt_pkg::*;

   lex_state_type st_ff, st_in;
   logic [1:0] esc_cnt_ff, esc_cnt_in;
   logic [8:0] esc_val_ff, esc_val_in;
   logic [3:0] sym_len_ff, sym_len_in;
   logic [KEYWORD_COUNT-1:0] kw_ff, kw_in;

   logic fire, eof, has;
   logic [7:0] c;
   qentry_type e;
   logic n_res;

   function automatic logic is_digit(input logic [7:0] x);
      return x >= "0" && x <= "9";
   endfunction
   function automatic logic is_ident(input logic [7:0] x);
      return (x >= "A" && x <= "Z") || (x >= "a" && x <= "z") || is_digit(x) || x == "_";
   endfunction

   assign in_ready = !q_full;
   assign fire = in_valid && in_ready;
   assign c = in_char;
   assign eof = in_eoi;
   assign has = !in_eoi;

   // Symbol end kind from current match vector.
   logic [6:0] sym_kind;
   always_comb begin
      sym_kind = K_SYMBOL;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (k < KW_TABLE_SIZE && kw_ff[k] && kw_len(k) == sym_len_ff &&
             int'(kw_len(k)) <= MAX_KEYWORD_LENGTH)
            sym_kind = kw_kind(k);
      end
   end

   // Match update for byte x at position pos.
   function automatic logic [KEYWORD_COUNT-1:0] kw_step(
      input logic [KEYWORD_COUNT-1:0] m, input logic [3:0] pos, input logic [7:0] x);
      logic [KEYWORD_COUNT-1:0] r;
      r = m;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (k >= KW_TABLE_SIZE || pos >= kw_len(k) || int'(pos) >= MAX_KEYWORD_LENGTH ||
             kw_char(k, int'(pos)) != x)
            r[k] = 1'b0;
      end
      return r;
   endfunction

   always_comb begin
      logic tk_first;
      logic [6:0] tk0;
      logic do_start;
      tk_first = 1'b0;
      tk0 = K_EOF;
      do_start = 1'b0;
      st_in = st_ff;
      esc_cnt_in = esc_cnt_ff;
      esc_val_in = esc_val_ff;
      sym_len_in = sym_len_ff;
      kw_in = kw_ff;
      e = '0;
      n_res = 1'b0;
      unique case (st_ff)
         ST_LINECOM: begin
            if (eof) do_start = 1'b1;
            else if (c == 8'h0a) st_in = ST_START;
         end
         ST_BLOCKCOM: begin
            if (eof) begin e.r0_kind = 1'b1; e.r0_tok = K_ERR_COMMENT; n_res = 1'b1;
               st_in = ST_START; end
            else if (c == "*") st_in = ST_BLOCKSTAR;
         end
         ST_BLOCKSTAR: begin
            if (eof) begin e.r0_kind = 1'b1; e.r0_tok = K_ERR_COMMENT; n_res = 1'b1;
               st_in = ST_START; end
            else if (c == "/") st_in = ST_START;
            else if (c != "*") st_in = ST_BLOCKCOM;
         end
         ST_STRING: begin
            if (eof) begin e.r0_kind = 1'b1; e.r0_tok = K_ERR_STRING; n_res = 1'b1;
               st_in = ST_START; end
            else if (c == "\"") begin e.r0_kind = 1'b1; e.r0_tok = K_STRING; n_res = 1'b1;
               st_in = ST_START; end
            else if (c == "\\") begin st_in = ST_STRESC; esc_cnt_in = '0; esc_val_in = '0; end
            else begin e.r0_byte = c; n_res = 1'b1; end
         end
         ST_STRESC: begin
            if (eof) begin e.r0_kind = 1'b1; e.r0_tok = K_ERR_STRING; n_res = 1'b1;
               st_in = ST_START; end
            else if (esc_cnt_ff != 2'd0) begin
               if (c >= "0" && c <= "7") begin
                  esc_val_in = {esc_val_ff[5:0], c[2:0]};
                  esc_cnt_in = esc_cnt_ff + 2'd1;
                  if (esc_cnt_in == 2'd3 || esc_cnt_in == 2'd0) begin
                     e.r0_byte = esc_val_in[7:0]; n_res = 1'b1;
                     esc_cnt_in = '0; st_in = ST_STRING;
                  end
               end else begin
                  e.r0_kind = 1'b1; e.r0_tok = K_ERR_OCTAL; n_res = 1'b1;
                  esc_cnt_in = '0; st_in = ST_START;
               end
            end else if (c >= "0" && c <= "7") begin
               esc_val_in = {6'd0, c[2:0]}; esc_cnt_in = 2'd1;
            end else begin
               n_res = 1'b1;
               if (c == "n") e.r0_byte = 8'h0a;
               else if (c == "t") e.r0_byte = 8'h09;
               else e.r0_byte = c;
               st_in = ST_STRING;
            end
         end
         ST_BRACED: begin
            if (eof) begin e.r0_kind = 1'b1; e.r0_tok = K_ERR_STRING; n_res = 1'b1;
               st_in = ST_START; end
            else if (c == "}") begin e.r0_kind = 1'b1; e.r0_tok = K_SYMBOL; n_res = 1'b1;
               st_in = ST_START; end
            else begin e.r0_byte = c; n_res = 1'b1; end
         end
         ST_SYMBOL: begin
            if (has && is_ident(c)) begin
               kw_in = kw_step(kw_ff, sym_len_ff, c);
               if (sym_len_ff != 4'd15) sym_len_in = sym_len_ff + 4'd1;
               e.r0_byte = c; n_res = 1'b1;
            end else begin tk_first = 1'b1; tk0 = sym_kind; do_start = 1'b1; end
         end
         ST_INTEGER: begin
            if (has && is_digit(c)) begin e.r0_byte = c; n_res = 1'b1; end
            else if (has && c == ".") begin e.r0_byte = c; n_res = 1'b1; st_in = ST_FLOAT; end
            else begin tk_first = 1'b1; tk0 = K_INTEGER; do_start = 1'b1; end
         end
         ST_FLOAT: begin
            if (has && is_digit(c)) begin e.r0_byte = c; n_res = 1'b1; end
            else begin tk_first = 1'b1; tk0 = K_FLOAT; do_start = 1'b1; end
         end
         ST_GREATER: begin
            if (has && c == "=") begin e.r0_kind = 1'b1; e.r0_tok = K_GREATEREQ; n_res = 1'b1;
               st_in = ST_START; end
            else begin tk_first = 1'b1; tk0 = K_GREATER; do_start = 1'b1; end
         end
         ST_LESS: begin
            if (has && c == "=") begin e.r0_kind = 1'b1; e.r0_tok = K_LESSEQ; n_res = 1'b1;
               st_in = ST_START; end
            else if (has && c == ">") begin e.r0_kind = 1'b1; e.r0_tok = K_DIFF;
               n_res = 1'b1; st_in = ST_START; end
            else begin tk_first = 1'b1; tk0 = K_LESS; do_start = 1'b1; end
         end
         ST_EQ: begin
            if (has && c == "=") begin e.r0_kind = 1'b1; e.r0_tok = K_EQ; n_res = 1'b1;
               st_in = ST_START; end
            else begin tk_first = 1'b1; tk0 = K_ASSIGN; do_start = 1'b1; end
         end
         ST_COLON: begin
            if (has && c == ":") begin e.r0_kind = 1'b1; e.r0_tok = K_DCOLON; n_res = 1'b1;
               st_in = ST_START; end
            else begin tk_first = 1'b1; tk0 = K_COLON; do_start = 1'b1; end
         end
         ST_SLASH: begin
            if (has && c == "/") st_in = ST_LINECOM;
            else if (has && c == "*") st_in = ST_BLOCKCOM;
            else begin tk_first = 1'b1; tk0 = K_SLASH; do_start = 1'b1; end
         end
         default: do_start = 1'b1;
      endcase

      if (do_start) begin
         // Start-state handling; result goes after the pending token if any.
         logic sres, sk;
         logic [6:0] stok;
         logic [7:0] sbyte;
         sres = 1'b0; sk = 1'b1; stok = K_EOF; sbyte = 8'd0;
         st_in = ST_START;
         if (eof) sres = 1'b1;
         else if (c == " " || (c >= 8'd9 && c <= 8'd13)) sres = 1'b0;
         else begin
            sres = 1'b1;
            priority case (c)
               "(": stok = K_LPAREN;
               ")": stok = K_RPAREN;
               "[": stok = K_LBRACK;
               "]": stok = K_RBRACK;
               "+": stok = K_PLUS;
               "-": stok = K_MINUS;
               "*": stok = K_STAR;
               "%": stok = K_PERCENT;
               ",": stok = K_COMMA;
               ".": stok = K_DOT;
               ";": stok = K_SEMI;
               "/": begin sres = 1'b0; st_in = ST_SLASH; end
               ":": begin sres = 1'b0; st_in = ST_COLON; end
               "=": begin sres = 1'b0; st_in = ST_EQ; end
               "<": begin sres = 1'b0; st_in = ST_LESS; end
               ">": begin sres = 1'b0; st_in = ST_GREATER; end
               "\"": begin sres = 1'b0; st_in = ST_STRING; end
               "{": begin sres = 1'b0; st_in = ST_BRACED; end
               default: begin
                  if (is_digit(c)) begin sk = 1'b0; sbyte = c; st_in = ST_INTEGER; end
                  else if (is_ident(c)) begin
                     sk = 1'b0; sbyte = c; st_in = ST_SYMBOL;
                     kw_in = kw_step({KEYWORD_COUNT{1'b1}}, 4'd0, c);
                     sym_len_in = 4'd1;
                  end else stok = K_ERR_CHAR;
               end
            endcase
         end
         if (tk_first) begin
            e.r0_kind = 1'b1; e.r0_tok = tk0; e.r0_byte = '0; n_res = 1'b1;
            // Second result of a pair is always a token except text after token.
            if (sres && !sk) begin
               // Token then text byte: marked by has_r1 with r1_tok all ones, text byte kept
               // in the r0_byte slot of the pair; the back end swaps the two on output.
               e.has_r1 = 1'b1; e.r1_tok = 7'h7f; e.r0_byte = sbyte;
            end else if (sres) begin
               e.has_r1 = 1'b1; e.r1_tok = stok;
            end
         end else if (sres) begin
            e.r0_kind = sk; e.r0_tok = sk ? stok : 7'd0; e.r0_byte = sk ? 8'd0 : sbyte;
            n_res = 1'b1;
         end
      end
   end

   assign q_push = fire && n_res;
   assign q_data = e;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_START;
         esc_cnt_ff <= '0;
         esc_val_ff <= '0;
         sym_len_ff <= '0;
         kw_ff <= {KEYWORD_COUNT{1'b1}};
      end else if (fire) begin
         st_ff <= st_in;
         esc_cnt_ff <= esc_cnt_in;
         esc_val_ff <= esc_val_in;
         sym_len_ff <= sym_len_in;
         kw_ff <= kw_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/slt_back.sv
// Lexer back end: queue of result entries, serialized onto the response channel.
// Depends on slt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slt_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_push,
   input  slt_pkg::qentry_type q_data,
   output logic                q_full,
   output logic                out_valid,
   input  wire logic           out_ready,
   output logic                out_rkind,
   output logic [6:0]          out_tok,
   output logic [7:0]          out_byte,
   output logic                out_last
);
   import slt_pkg::*;
   localparam int AW = $clog2(QUEUE_DEPTH);

   qentry_type mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic half_ff, half_in;
   logic pop, take;
   qentry_type h;

   assign h = mem_ff[rd_ff];
   assign q_full = cnt_ff == AW'(0) + (AW+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign take = out_valid && out_ready;

   // A pair with r1_tok all ones is token then text byte.
   always_comb begin
      logic tt;
      tt = h.has_r1 && h.r1_tok == 7'h7f;
      if (!half_ff) begin
         out_rkind = h.r0_kind;
         out_tok = h.r0_tok;
         out_byte = tt ? 8'd0 : h.r0_byte;
         out_last = !h.has_r1;
      end else begin
         out_rkind = !tt;
         out_tok = tt ? 7'd0 : h.r1_tok;
         out_byte = tt ? h.r0_byte : 8'd0;
         out_last = 1'b1;
      end
   end

   assign pop = take && (half_ff || !h.has_r1);
   assign half_in = take ? (!half_ff && h.has_r1) : half_ff;
   assign rd_in = pop ? rd_ff + AW'(1) : rd_ff;
   assign wr_in = q_push ? wr_ff + AW'(1) : wr_ff;
   assign cnt_in = cnt_ff + (AW+1)'(q_push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wr_ff] <= q_data;
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0; half_ff <= 1'b0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in; half_ff <= half_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/script_lexer_tokenizer.sv
// Top level of the script lexer: front end, result queue and back end.
// Depends on slt_pkg, slt_if, slt_front, slt_back.
// One source byte per cycle is accepted while the four-entry result queue has
// room; each byte gives zero, one or two responses, and the two responses of a
// byte go out one after the other on the response port. Keyword matching is a
// parallel compare of the byte against every keyword column of the table.
`timescale 1ns / 1ps
`default_nettype none
module script_lexer_tokenizer #(
   parameter int KEYWORD_COUNT = slt_pkg::KEYWORD_COUNT_DEF,
   parameter int MAX_KEYWORD_LENGTH = slt_pkg::MAX_KEYWORD_LENGTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   slt_req_if.sink  req,
   slt_rsp_if.source rsp
);
   import slt_pkg::*;
   qentry_type q_data;
   logic q_push, q_full;

   slt_front #(.KEYWORD_COUNT(KEYWORD_COUNT), .MAX_KEYWORD_LENGTH(MAX_KEYWORD_LENGTH)) u_front (
      .clock, .reset, .in_valid(req.valid), .in_char(req.char_byte),
      .in_eoi(req.end_of_input), .in_ready(req.ready),
      .q_push, .q_data, .q_full);

   slt_back u_back (
      .clock, .reset, .q_push, .q_data, .q_full,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rkind(rsp.result_kind),
      .out_tok(rsp.token_kind), .out_byte(rsp.text_byte), .out_last(rsp.last));
endmodule
`default_nettype wire

// File: rtl/slt_checker.sv
// Port-level checks on the lexer response stream, bound to the top level.
// Depends on assert_macros.svh and slt_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module slt_assertions (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_result_kind,
   input wire logic [6:0] rsp_token_kind,
   input wire logic [7:0] rsp_text_byte
);
   import slt_pkg::*;
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `CHK_IMPL(a_text_kind, clock, reset, rsp_valid && !rsp_result_kind,
      rsp_token_kind == K_EOF, "text result with token kind")
   `CHK_IMPL(a_tok_byte, clock, reset, rsp_valid && rsp_result_kind,
      rsp_text_byte == 8'd0, "token result with text byte")
   `CHK_IMPL(a_tok_range, clock, reset, rsp_valid && rsp_result_kind,
      rsp_token_kind <= K_ERR_STRING, "token kind out of range")
endmodule

bind script_lexer_tokenizer slt_assertions u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_result_kind(rsp.result_kind), .rsp_token_kind(rsp.token_kind),
   .rsp_text_byte(rsp.text_byte));
`default_nettype wire

// File: dv/slt_checker.sv
// Checker for the script lexer: watches request and response channels,
// predicts the responses of every accepted byte and compares them in order.
// Depends on slt_pkg and slt_if.
`timescale 1ns / 1ps
module slt_checker (
   input  logic      clock,
   input  logic      reset,
   slt_req_if.sink   req_mon,
   slt_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count
);
   import slt_pkg::*;

   typedef enum logic [3:0] {
      LX_START, LX_STRING, LX_STRESC, LX_SYMBOL, LX_BRACED, LX_INTEGER, LX_FLOAT,
      LX_GREATER, LX_LESS, LX_EQ, LX_COLON, LX_SLASH, LX_LINECOM, LX_BLOCKCOM,
      LX_BLOCKSTAR
   } lex_mode_type;

   typedef struct packed {
      logic       result_kind;
      logic [6:0] token_kind;
      logic [7:0] text_byte;
      logic       last;
   } lex_result_type;

   localparam int NKW = 44;
   string kw_text [NKW] = '{"PROGRAM", "IMPORT", "BEGIN", "END", "CALL", "FOR", "TO",
      "STEP", "WHILE", "DO", "WITH", "AS", "OF", "ARRAY", "RETURNS", "VAR", "IF",
      "THEN", "ELSE", "AND", "OR", "NOT", "NEW", "COPYOF", "DETACH", "SIZEOF",
      "DELETE", "TYPE", "TYPENS", "ISSET", "ISNULL", "ISTYPE", "ISINSTANCE", "STRLEN",
      "EXTERNAL", "RETURN", "TRY", "CATCH", "THROW", "DEFINE", "EXTENSION", "TRUE",
      "FALSE", "NULL"};

   lex_mode_type   mode;
   logic [1:0]     esc_cnt;
   logic [8:0]     esc_val;
   logic [3:0]     sym_len;
   logic [NKW-1:0] kw_hits;
   lex_result_type expected_results[$];
   lex_result_type step_out[$];

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_ident(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || is_digit(c) || c == "_";
   endfunction

   task automatic push_text(logic [7:0] c);
      step_out.push_back('{1'b0, 7'd0, c, 1'b0});
   endtask

   task automatic push_token(logic [6:0] k);
      step_out.push_back('{1'b1, k, 8'd0, 1'b0});
   endtask

   task automatic add_symbol_byte(logic [7:0] c);
      for (int k = 0; k < NKW; k++)
         if (kw_hits[k] && (sym_len >= kw_text[k].len() || kw_text[k].getc(sym_len) != c))
            kw_hits[k] = 1'b0;
      if (sym_len < 15) sym_len++;
      push_text(c);
   endtask

   task automatic close_symbol();
      logic [6:0] kind;
      kind = K_SYMBOL;
      for (int k = NKW - 1; k >= 0; k--)
         if (kw_hits[k] && kw_text[k].len() == sym_len)
            kind = (k == 43) ? 7'd68 : (k == 42) ? 7'd67 : 7'(26 + k);
      push_token(kind);
   endtask

   task automatic lex_from_start(logic [7:0] c, bit eoi);
      mode = LX_START;
      if (eoi) begin
         push_token(K_EOF);
         return;
      end
      if (c == " " || (c >= 9 && c <= 13)) return;
      case (c)
         "(": push_token(K_LPAREN);
         ")": push_token(K_RPAREN);
         "[": push_token(K_LBRACK);
         "]": push_token(K_RBRACK);
         "+": push_token(K_PLUS);
         "-": push_token(K_MINUS);
         "*": push_token(K_STAR);
         "%": push_token(K_PERCENT);
         ",": push_token(K_COMMA);
         ".": push_token(K_DOT);
         ";": push_token(K_SEMI);
         "/": mode = LX_SLASH;
         ":": mode = LX_COLON;
         "=": mode = LX_EQ;
         "<": mode = LX_LESS;
         ">": mode = LX_GREATER;
         "\"": mode = LX_STRING;
         "{": mode = LX_BRACED;
         default: begin
            if (is_digit(c)) begin
               push_text(c);
               mode = LX_INTEGER;
            end else if (is_ident(c)) begin
               sym_len = 0;
               kw_hits = '1;
               mode = LX_SYMBOL;
               add_symbol_byte(c);
            end else begin
               push_token(K_ERR_CHAR);
            end
         end
      endcase
   endtask

   task automatic lex_byte(logic [7:0] c, bit eoi);
      bit has;
      has = !eoi;
      step_out.delete();
      case (mode)
         LX_LINECOM:
            if (eoi) lex_from_start(c, 1'b1);
            else if (c == "\n") mode = LX_START;
         LX_BLOCKCOM:
            if (eoi) begin
               push_token(K_ERR_COMMENT);
               mode = LX_START;
            end else if (c == "*") mode = LX_BLOCKSTAR;
         LX_BLOCKSTAR:
            if (eoi) begin
               push_token(K_ERR_COMMENT);
               mode = LX_START;
            end else if (c == "/") mode = LX_START;
            else if (c != "*") mode = LX_BLOCKCOM;
         LX_STRING:
            if (eoi) begin
               push_token(K_ERR_STRING);
               mode = LX_START;
            end else if (c == "\"") begin
               push_token(K_STRING);
               mode = LX_START;
            end else if (c == "\\") begin
               mode = LX_STRESC;
               esc_cnt = 0;
               esc_val = 0;
            end else push_text(c);
         LX_STRESC:
            if (eoi) begin
               push_token(K_ERR_STRING);
               mode = LX_START;
            end else if (esc_cnt != 0) begin
               if (c >= "0" && c <= "7") begin
                  esc_val = {esc_val[5:0], 3'(c - "0")};
                  esc_cnt = esc_cnt + 2'd1;
                  if (!(esc_cnt < 3 && esc_cnt != 0)) begin
                     push_text(esc_val[7:0]);
                     esc_cnt = 0;
                     mode = LX_STRING;
                  end
               end else begin
                  push_token(K_ERR_OCTAL);
                  esc_cnt = 0;
                  mode = LX_START;
               end
            end else if (c >= "0" && c <= "7") begin
               esc_val = 9'(c - "0");
               esc_cnt = 1;
            end else begin
               push_text(c == "n" ? 8'h0a : c == "t" ? 8'h09 : c);
               mode = LX_STRING;
            end
         LX_BRACED:
            if (eoi) begin
               push_token(K_ERR_STRING);
               mode = LX_START;
            end else if (c == "}") begin
               push_token(K_SYMBOL);
               mode = LX_START;
            end else push_text(c);
         LX_SYMBOL:
            if (has && is_ident(c)) add_symbol_byte(c);
            else begin
               close_symbol();
               lex_from_start(c, eoi);
            end
         LX_INTEGER:
            if (has && is_digit(c)) push_text(c);
            else if (has && c == ".") begin
               push_text(c);
               mode = LX_FLOAT;
            end else begin
               push_token(K_INTEGER);
               lex_from_start(c, eoi);
            end
         LX_FLOAT:
            if (has && is_digit(c)) push_text(c);
            else begin
               push_token(K_FLOAT);
               lex_from_start(c, eoi);
            end
         LX_GREATER:
            if (has && c == "=") begin
               push_token(K_GREATEREQ);
               mode = LX_START;
            end else begin
               push_token(K_GREATER);
               lex_from_start(c, eoi);
            end
         LX_LESS:
            if (has && c == "=") begin
               push_token(K_LESSEQ);
               mode = LX_START;
            end else if (has && c == ">") begin
               push_token(K_DIFF);
               mode = LX_START;
            end else begin
               push_token(K_LESS);
               lex_from_start(c, eoi);
            end
         LX_EQ:
            if (has && c == "=") begin
               push_token(K_EQ);
               mode = LX_START;
            end else begin
               push_token(K_ASSIGN);
               lex_from_start(c, eoi);
            end
         LX_COLON:
            if (has && c == ":") begin
               push_token(K_DCOLON);
               mode = LX_START;
            end else begin
               push_token(K_COLON);
               lex_from_start(c, eoi);
            end
         LX_SLASH:
            if (has && c == "/") mode = LX_LINECOM;
            else if (has && c == "*") mode = LX_BLOCKCOM;
            else begin
               push_token(K_SLASH);
               lex_from_start(c, eoi);
            end
         default: lex_from_start(c, eoi);
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) expected_results.push_back(step_out[i]);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      lex_result_type want;
      if (reset) begin
         mode = LX_START;
         esc_cnt = 0;
         esc_val = 0;
         sym_len = 0;
         kw_hits = '1;
         expected_results.delete();
      end else begin
         // compare first: a response never comes out in the cycle its byte is taken
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response token_kind", rsp_mon.token_kind, -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.result_kind !== want.result_kind)
                  report_mismatch("result_kind", rsp_mon.result_kind, want.result_kind);
               if (rsp_mon.token_kind !== want.token_kind)
                  report_mismatch("token_kind", rsp_mon.token_kind, want.token_kind);
               if (rsp_mon.text_byte !== want.text_byte)
                  report_mismatch("text_byte", rsp_mon.text_byte, want.text_byte);
               if (rsp_mon.last !== want.last)
                  report_mismatch("last", rsp_mon.last, want.last);
            end
         end
         if (req_mon.valid && req_mon.ready)
            lex_byte(req_mon.char_byte, req_mon.end_of_input);
      end
      pending_count = expected_results.size();
   end
endmodule

// File: dv/tb_top.sv
// Testbench top for the script lexer: clock, reset, byte stimulus, response
// back-pressure and the verdict. Depends on slt_pkg, slt_if, slt_checker.
`timescale 1ns / 1ps
module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   int   sent_count = 0;
   bit   stim_done = 1'b0;
   bit   long_hold = 1'b0;

   slt_req_if req ();
   slt_rsp_if rsp ();

   script_lexer_tokenizer dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   slt_checker u_checker (.clock(clock), .reset(reset), .req_mon(req), .rsp_mon(rsp),
      .fail_count(fail_count), .pending_count(pending_count));

   string words [8] = '{"PROGRAM", "ISINSTANCE", "EXTENSION", "COPYOF", "TRUE", "FALSE",
      "ISINSTANCES", "TYPENSX"};
   string pieces [16] = '{"x_9 ", "12.5;", "\"a\\n\\101\\777b\\tq\"", "{br ace}", "<>", "<=",
      ">=", "==", "::", "// note\n", "/* c ** */", "(a,b)", "[1]+2-3*4%5", "a.b", "\\",
      "7.x"};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.char_byte = 8'd0;
      req.end_of_input = 1'b0;
      rsp.ready = 1'b0;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   task automatic send_byte(logic [7:0] c, bit eoi);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.char_byte <= c;
      req.end_of_input <= eoi;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s.getc(i), 1'b0);
   endtask

   // Receiver: random stalls, one long hold-off while the sender keeps going.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp.ready <= 1'b0;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: keywords, long symbols, escapes, errors, eof cases
      send_text("PROGRAM ISINSTANCE TRUE FALSE ISINSTANCESX 0 9.");
      send_byte(8'd0, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_text("\"\\12x");
      send_text("/*");
      send_byte(8'd0, 1'b1);
      send_text("\"ab");
      send_byte(8'd0, 1'b1);
      send_text("{q");
      send_byte(8'd0, 1'b1);
      long_hold = 1'b1;
      while (sent_count < 1000) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            if ($urandom_range(0, 1)) send_text(words[$urandom_range(0, 7)]);
            else send_text(pieces[$urandom_range(0, 15)]);
            send_byte(" ", 1'b0);
         end else if (pick < 8) begin
            send_byte(8'($urandom_range(32, 126)), 1'b0);
         end else if (pick == 8) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
      send_byte(8'd0, 1'b1);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// File: script_lexer_tokenizer.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_if.sv
rtl/slt_front.sv
rtl/slt_back.sv
rtl/script_lexer_tokenizer.sv
rtl/slt_checker.sv
dv/slt_checker.sv
dv/tb_top.sv
